### sv/qcc_pkg.sv
// Shared widths and constants for the quad cell centroid block.
package qcc_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = 33;   // corner difference
  localparam int unsigned SumW   = 34;   // sum of three or four corners
  localparam int unsigned ProdW  = 66;   // one coordinate product
  localparam int unsigned CrossW = 67;   // twice a triangle area
  localparam int unsigned TotW   = 68;   // twice the cell area
  localparam int unsigned DenW   = 70;   // three times the total
  localparam int unsigned LoW    = 34;   // low slice of a cross product
  localparam int unsigned NumW   = 104;  // numerator and remainder width
  localparam int unsigned DvW    = 71;   // doubled divisor magnitude
  localparam int unsigned QW     = 33;   // quotient bits resolved by the divider
  localparam int unsigned AddrW  = 3;
  localparam logic [AddrW-1:0] AddrMeanMode = 3'd0;
  localparam logic [CoordW-1:0] SatMax = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] SatMin = 32'h8000_0000;
endpackage

### sv/qcc_if.sv
// Handshake interfaces for the corner input channel and the centroid output channel.
interface qcc_in_if;
  logic valid;
  logic ready;
  logic [qcc_pkg::CoordW-1:0] sw_x, sw_y, se_x, se_y, ne_x, ne_y, nw_x, nw_y;
  modport source (output valid, sw_x, sw_y, se_x, se_y, ne_x, ne_y, nw_x, nw_y,
                  input ready);
  modport sink (input valid, sw_x, sw_y, se_x, se_y, ne_x, ne_y, nw_x, nw_y,
                output ready);
endinterface

interface qcc_out_if;
  logic valid;
  logic ready;
  logic [qcc_pkg::CoordW-1:0] centroid_x, centroid_y;
  logic degenerate;
  modport source (output valid, centroid_x, centroid_y, degenerate, input ready);
  modport sink (input valid, centroid_x, centroid_y, degenerate, output ready);
endinterface

### sv/quad_cell_centroid_top.sv
// Quad cell centroid: pipelined corner mean and area weighted centroid of one cell.
//
// Corners enter on in_i (SW, SE, NE, NW, Q16.16 signed); one result leaves on
// out_o per cell. A transfer happens on a channel when valid and ready are high.
// The APB register mean_mode (address 0) picks the simple corner mean (0) or the
// area weighted triangle centroid (1); it is sampled with each cell as it enters.
// Every cell passes from its input transfer to out_o through seven arithmetic
// stages (differences, products, cross products, split partial products,
// numerator sums, magnitudes, range check), 33 restoring division stages that
// each resolve one quotient bit for x and y side by side, and the output
// register. A new cell may enter on every cycle while out_o is not stalled, so
// the sustained rate is one cell per cycle. When the receiver holds ready low
// while a result is waiting, the whole pipeline holds and in_i.ready drops;
// nothing is lost or repeated. Reset clears all stage valid bits and sets
// mean_mode to simple mode. A zero total area in weighted mode gives a zero
// centroid with degenerate set; quotients outside the Q16.16 range saturate.
module quad_cell_centroid_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qcc_in_if.sink                      in_i,
  qcc_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qcc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int unsigned NDiv = qcc_pkg::QW;
  localparam int unsigned NSt  = 7 + NDiv + 1;

  typedef struct packed {
    logic [qcc_pkg::NumW-1:0] rx, ry;
    logic [qcc_pkg::DvW-1:0]  dv;
    logic [qcc_pkg::QW-1:0]   qx, qy;
    logic negx, negy, hix, hiy;
    logic [qcc_pkg::CoordW-1:0] sx, sy;
    logic mode, zero;
  } div_t;

  function automatic logic [qcc_pkg::CoordW-1:0] simple_mean(
      input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
      input logic [31:0] d);
    logic signed [qcc_pkg::SumW-1:0] s;
    logic [qcc_pkg::SumW-1:0] m, q;
    s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b})
      + $signed({{2{c[31]}}, c}) + $signed({{2{d[31]}}, d});
    m = s[qcc_pkg::SumW-1] ? -s : s;
    q = (m + 34'd2) >> 2;
    if (s[qcc_pkg::SumW-1]) q = -q;
    return q[qcc_pkg::CoordW-1:0];
  endfunction

  function automatic logic signed [qcc_pkg::DiffW-1:0] dif(input logic [31:0] a,
                                                          input logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic signed [qcc_pkg::SumW-1:0] sum3(input logic [31:0] a,
      input logic [31:0] b, input logic [31:0] c);
    return $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b})
         + $signed({{2{c[31]}}, c});
  endfunction

  // Configuration register.
  logic mode_q;
  assign pready = 1'b1;
  assign prdata = {31'b0, mode_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == qcc_pkg::AddrMeanMode) begin
      mode_q <= pwdata[0];
    end
  end

  // Global pipeline advance: everything moves unless a finished result is stalled.
  logic [NSt-1:0] v_q;
  logic adv;
  assign adv = !v_q[NSt-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSt-2:0], in_i.valid};
    end
  end

  // Stage A: corner differences, triangle corner sums and the simple mean.
  logic signed [qcc_pkg::DiffW-1:0] a_dx1_q, a_dy1_q, a_dx2_q, a_dy2_q, a_dx3_q, a_dy3_q;
  logic signed [qcc_pkg::SumW-1:0]  a_sax_q, a_sbx_q, a_say_q, a_sby_q;
  logic [qcc_pkg::CoordW-1:0]       a_sx_q, a_sy_q;
  logic                             a_mode_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_dx1_q  <= dif(in_i.se_x, in_i.sw_x);
      a_dy1_q  <= dif(in_i.se_y, in_i.sw_y);
      a_dx2_q  <= dif(in_i.ne_x, in_i.sw_x);
      a_dy2_q  <= dif(in_i.ne_y, in_i.sw_y);
      a_dx3_q  <= dif(in_i.nw_x, in_i.sw_x);
      a_dy3_q  <= dif(in_i.nw_y, in_i.sw_y);
      a_sax_q  <= sum3(in_i.sw_x, in_i.se_x, in_i.ne_x);
      a_sbx_q  <= sum3(in_i.sw_x, in_i.ne_x, in_i.nw_x);
      a_say_q  <= sum3(in_i.sw_y, in_i.se_y, in_i.ne_y);
      a_sby_q  <= sum3(in_i.sw_y, in_i.ne_y, in_i.nw_y);
      a_sx_q   <= simple_mean(in_i.sw_x, in_i.se_x, in_i.ne_x, in_i.nw_x);
      a_sy_q   <= simple_mean(in_i.sw_y, in_i.se_y, in_i.ne_y, in_i.nw_y);
      a_mode_q <= mode_q;
    end
  end

  // Stage B: the four coordinate products of the two cross products.
  logic signed [qcc_pkg::ProdW-1:0] b_p1_q, b_p2_q, b_p3_q, b_p4_q;
  logic signed [qcc_pkg::SumW-1:0]  b_sax_q, b_sbx_q, b_say_q, b_sby_q;
  logic [qcc_pkg::CoordW-1:0]       b_sx_q, b_sy_q;
  logic                             b_mode_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_p1_q   <= a_dx1_q * a_dy2_q;
      b_p2_q   <= a_dy1_q * a_dx2_q;
      b_p3_q   <= a_dx2_q * a_dy3_q;
      b_p4_q   <= a_dy2_q * a_dx3_q;
      b_sax_q  <= a_sax_q;
      b_sbx_q  <= a_sbx_q;
      b_say_q  <= a_say_q;
      b_sby_q  <= a_sby_q;
      b_sx_q   <= a_sx_q;
      b_sy_q   <= a_sy_q;
      b_mode_q <= a_mode_q;
    end
  end

  // Stage C: doubled triangle areas and their sum.
  logic signed [qcc_pkg::CrossW-1:0] c_c1_q, c_c2_q;
  logic signed [qcc_pkg::TotW-1:0]   c_tot_q;
  logic signed [qcc_pkg::CrossW-1:0] c_c1_d, c_c2_d;
  logic signed [qcc_pkg::SumW-1:0]   c_sax_q, c_sbx_q, c_say_q, c_sby_q;
  logic [qcc_pkg::CoordW-1:0]        c_sx_q, c_sy_q;
  logic                              c_mode_q;
  assign c_c1_d = $signed({b_p1_q[qcc_pkg::ProdW-1], b_p1_q})
                - $signed({b_p2_q[qcc_pkg::ProdW-1], b_p2_q});
  assign c_c2_d = $signed({b_p3_q[qcc_pkg::ProdW-1], b_p3_q})
                - $signed({b_p4_q[qcc_pkg::ProdW-1], b_p4_q});
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_c1_q   <= c_c1_d;
      c_c2_q   <= c_c2_d;
      c_tot_q  <= $signed({c_c1_d[qcc_pkg::CrossW-1], c_c1_d})
                + $signed({c_c2_d[qcc_pkg::CrossW-1], c_c2_d});
      c_sax_q  <= b_sax_q;
      c_sbx_q  <= b_sbx_q;
      c_say_q  <= b_say_q;
      c_sby_q  <= b_sby_q;
      c_sx_q   <= b_sx_q;
      c_sy_q   <= b_sy_q;
      c_mode_q <= b_mode_q;
    end
  end

  // Stage D: split partial products of corner sums and areas, and the divisor.
  localparam int unsigned HiW = qcc_pkg::CrossW - qcc_pkg::LoW;
  localparam int unsigned PloW = qcc_pkg::SumW + qcc_pkg::LoW + 1;
  localparam int unsigned PhiW = qcc_pkg::SumW + HiW;
  logic signed [PloW-1:0] d_xal_q, d_xbl_q, d_yal_q, d_ybl_q;
  logic signed [PhiW-1:0] d_xah_q, d_xbh_q, d_yah_q, d_ybh_q;
  logic signed [qcc_pkg::LoW:0] c1lo, c2lo;
  logic signed [HiW-1:0] c1hi, c2hi;
  logic signed [qcc_pkg::DenW-1:0] d_den_q;
  logic [qcc_pkg::CoordW-1:0] d_sx_q, d_sy_q;
  logic d_mode_q, d_zero_q;
  assign c1lo = $signed({1'b0, c_c1_q[qcc_pkg::LoW-1:0]});
  assign c2lo = $signed({1'b0, c_c2_q[qcc_pkg::LoW-1:0]});
  assign c1hi = c_c1_q[qcc_pkg::CrossW-1:qcc_pkg::LoW];
  assign c2hi = c_c2_q[qcc_pkg::CrossW-1:qcc_pkg::LoW];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_xal_q  <= c_sax_q * c1lo;
      d_xbl_q  <= c_sbx_q * c2lo;
      d_yal_q  <= c_say_q * c1lo;
      d_ybl_q  <= c_sby_q * c2lo;
      d_xah_q  <= c_sax_q * c1hi;
      d_xbh_q  <= c_sbx_q * c2hi;
      d_yah_q  <= c_say_q * c1hi;
      d_ybh_q  <= c_sby_q * c2hi;
      d_den_q  <= $signed({{2{c_tot_q[qcc_pkg::TotW-1]}}, c_tot_q})
                + $signed({c_tot_q[qcc_pkg::TotW-1], c_tot_q, 1'b0});
      d_zero_q <= (c_tot_q == '0);
      d_sx_q   <= c_sx_q;
      d_sy_q   <= c_sy_q;
      d_mode_q <= c_mode_q;
    end
  end

  // Stage E: full numerators.
  function automatic logic signed [qcc_pkg::NumW-1:0] join_pp(
      input logic signed [PhiW-1:0] hi, input logic signed [PloW-1:0] lo);
    logic signed [qcc_pkg::NumW-1:0] h, l;
    h = $signed({{(qcc_pkg::NumW-PhiW){hi[PhiW-1]}}, hi});
    l = $signed({{(qcc_pkg::NumW-PloW){lo[PloW-1]}}, lo});
    return (h <<< qcc_pkg::LoW) + l;
  endfunction

  logic signed [qcc_pkg::NumW-1:0] e_nx_q, e_ny_q;
  logic signed [qcc_pkg::DenW-1:0] e_den_q;
  logic [qcc_pkg::CoordW-1:0] e_sx_q, e_sy_q;
  logic e_mode_q, e_zero_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_nx_q   <= join_pp(d_xah_q, d_xal_q) + join_pp(d_xbh_q, d_xbl_q);
      e_ny_q   <= join_pp(d_yah_q, d_yal_q) + join_pp(d_ybh_q, d_ybl_q);
      e_den_q  <= d_den_q;
      e_zero_q <= d_zero_q;
      e_sx_q   <= d_sx_q;
      e_sy_q   <= d_sy_q;
      e_mode_q <= d_mode_q;
    end
  end

  // Stage F: magnitudes; the rounded quotient is (2|n| + |d|) / (2|d|).
  logic [qcc_pkg::NumW-1:0] f_nx_q, f_ny_q;
  logic [qcc_pkg::DvW-1:0]  f_dv_q;
  logic [qcc_pkg::NumW-1:0] abs_nx, abs_ny, abs_d;
  logic [qcc_pkg::DenW-1:0] abs_den;
  logic f_negx_q, f_negy_q, f_mode_q, f_zero_q;
  logic [qcc_pkg::CoordW-1:0] f_sx_q, f_sy_q;
  assign abs_nx  = e_nx_q[qcc_pkg::NumW-1] ? -e_nx_q : e_nx_q;
  assign abs_ny  = e_ny_q[qcc_pkg::NumW-1] ? -e_ny_q : e_ny_q;
  assign abs_den = e_den_q[qcc_pkg::DenW-1] ? -e_den_q : e_den_q;
  assign abs_d   = {{(qcc_pkg::NumW-qcc_pkg::DenW){1'b0}}, abs_den};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_nx_q   <= {abs_nx[qcc_pkg::NumW-2:0], 1'b0} + abs_d;
      f_ny_q   <= {abs_ny[qcc_pkg::NumW-2:0], 1'b0} + abs_d;
      f_dv_q   <= {abs_den, 1'b0};
      f_negx_q <= e_nx_q[qcc_pkg::NumW-1] ^ e_den_q[qcc_pkg::DenW-1];
      f_negy_q <= e_ny_q[qcc_pkg::NumW-1] ^ e_den_q[qcc_pkg::DenW-1];
      f_zero_q <= e_zero_q;
      f_sx_q   <= e_sx_q;
      f_sy_q   <= e_sy_q;
      f_mode_q <= e_mode_q;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  div_t dq [NDiv+1];
  div_t dn [NDiv];
  always_comb begin
    logic [qcc_pkg::NumW-1:0] dsh;
    logic gex, gey;
    dsh = '0;
    gex = 1'b0;
    gey = 1'b0;
    for (int k = 0; k < NDiv; k++) begin
      dsh = {{(qcc_pkg::NumW-qcc_pkg::DvW){1'b0}}, dq[k].dv} << (NDiv - 1 - k);
      gex = dq[k].rx >= dsh;
      gey = dq[k].ry >= dsh;
      dn[k]    = dq[k];
      dn[k].rx = gex ? dq[k].rx - dsh : dq[k].rx;
      dn[k].ry = gey ? dq[k].ry - dsh : dq[k].ry;
      dn[k].qx = {dq[k].qx[qcc_pkg::QW-2:0], gex};
      dn[k].qy = {dq[k].qy[qcc_pkg::QW-2:0], gey};
    end
  end

  // Stage G: quotients of 2^33 or more saturate in any case; flag them here.
  logic [qcc_pkg::NumW-1:0] dv_top;
  assign dv_top = {f_dv_q, {qcc_pkg::QW{1'b0}}};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dq[0].rx   <= f_nx_q;
      dq[0].ry   <= f_ny_q;
      dq[0].dv   <= f_dv_q;
      dq[0].qx   <= '0;
      dq[0].qy   <= '0;
      dq[0].hix  <= f_nx_q >= dv_top;
      dq[0].hiy  <= f_ny_q >= dv_top;
      dq[0].negx <= f_negx_q;
      dq[0].negy <= f_negy_q;
      dq[0].sx   <= f_sx_q;
      dq[0].sy   <= f_sy_q;
      dq[0].mode <= f_mode_q;
      dq[0].zero <= f_zero_q;
      for (int k = 0; k < NDiv; k++) begin
        dq[k+1] <= dn[k];
      end
    end
  end

  // Output stage: sign, saturation and mode selection.
  function automatic logic [qcc_pkg::CoordW-1:0] sat_q(input logic [qcc_pkg::QW-1:0] q,
                                                      input logic neg, input logic hi);
    logic [qcc_pkg::CoordW-1:0] r;
    if (neg) begin
      if (hi || q >= {1'b0, qcc_pkg::SatMin}) r = qcc_pkg::SatMin;
      else r = -q[qcc_pkg::CoordW-1:0];
    end else begin
      if (hi || q > {1'b0, qcc_pkg::SatMax}) r = qcc_pkg::SatMax;
      else r = q[qcc_pkg::CoordW-1:0];
    end
    return r;
  endfunction

  logic [qcc_pkg::CoordW-1:0] o_x_q, o_y_q;
  logic o_deg_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!dq[NDiv].mode) begin
        o_x_q   <= dq[NDiv].sx;
        o_y_q   <= dq[NDiv].sy;
        o_deg_q <= 1'b0;
      end else if (dq[NDiv].zero) begin
        o_x_q   <= '0;
        o_y_q   <= '0;
        o_deg_q <= 1'b1;
      end else begin
        o_x_q   <= sat_q(dq[NDiv].qx, dq[NDiv].negx, dq[NDiv].hix);
        o_y_q   <= sat_q(dq[NDiv].qy, dq[NDiv].negy, dq[NDiv].hiy);
        o_deg_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = v_q[NSt-1];
  assign out_o.centroid_x = o_x_q;
  assign out_o.centroid_y = o_y_q;
  assign out_o.degenerate = o_deg_q;
endmodule
